>>> rtl/core/art_pkg.sv
package art_pkg;

  localparam int unsigned AddrW = 64;

  // Command codes carried in the input item.
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_REVERSE = 2'd2;

  // Status codes carried in the result item.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_SKIP = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] region_size;
    logic [AddrW-1:0] data_base;
    logic             is_text;
    logic             is_empty;
    logic             is_stub;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot_index;
    logic             code_hit;
    logic             empty_hit;
    logic [AddrW-1:0] mapped_value;
  } out_item_t;

  // Request to the shared add/subtract and range compare unit.
  typedef struct packed {
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    logic             sub;
    logic [AddrW-1:0] len;
  } unit_req_t;

  typedef struct packed {
    logic [AddrW-1:0] sum;
    logic             in_range;
    logic             zero;
  } unit_rsp_t;

endpackage

>>> rtl/core/art_unit.sv
module art_unit (
  input  art_pkg::unit_req_t req_i,
  output art_pkg::unit_rsp_t rsp_o
);
  import art_pkg::*;

  logic [AddrW:0]   sum_w;
  logic [AddrW-1:0] b_x;

  // In subtract mode the carry out is set when a >= b, so a - b did not wrap.
  assign b_x   = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_w = {1'b0, req_i.a} + {1'b0, b_x} + (AddrW+1)'(req_i.sub);

  assign rsp_o.sum      = sum_w[AddrW-1:0];
  assign rsp_o.zero     = (sum_w[AddrW-1:0] == '0);
  assign rsp_o.in_range = req_i.sub && sum_w[AddrW] && (sum_w[AddrW-1:0] < req_i.len);

endmodule

>>> rtl/core/address_region_table_core.sv
// An insert scans the seen-base table, runs a purge scan of the region table when needed,
// then writes the next free slot unless the table is full or the region is skipped; a lookup
// or reverse lookup scans the region table and on a hit adds the recorded offset in a finish
// step, a reverse lookup stopping at its first hit; an unknown command goes straight to the
// response. One item is handled at a time: a new one is taken only after the result is loaded.
// Reset clears the valid bits and the slot and base counters; the table storage needs no clear.
module address_region_table_core #(
  parameter int unsigned REGIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  art_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output art_pkg::out_item_t  out_item_o
);
  import art_pkg::*;

  // Index width for the storage and counter width that can hold REGIONS itself.
  localparam int unsigned IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned CW = $clog2(REGIONS + 1);

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] data;
    logic             text;
    logic             empty;
    logic             stub;
  } region_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic             empty;
  } seen_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH,
    ST_RESP
  } state_e;

  // What the current slot scan is looking for.
  typedef enum logic [1:0] {
    MODE_SEEN,
    MODE_PURGE,
    MODE_LOOK,
    MODE_REV
  } mode_e;

  // The region and seen-base tables are memories with one write and one
  // registered read port. Validity lives in flip-flops so reset clears it.
  region_t region_mem [REGIONS];
  seen_t   seen_mem   [REGIONS];
  region_t reg_rd_q;
  seen_t   seen_rd_q;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  in_item_t         req_q, req_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    limit_q, limit_d;
  logic             pend_q, pend_d;
  logic [IW-1:0]    pend_idx_q, pend_idx_d;
  logic             stop_q, stop_d;
  logic             found_q, found_d;
  logic             first_empty_q, first_empty_d;
  logic             hit_q, hit_d;
  logic             code_q, code_d;
  logic [IW-1:0]    slot_q, slot_d;
  logic [AddrW-1:0] diff_q, diff_d;
  logic [AddrW-1:0] other_q, other_d;
  logic [REGIONS-1:0] valid_q, valid_d;
  logic [CW-1:0]    next_slot_q, next_slot_d;
  logic [CW-1:0]    seen_count_q, seen_count_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  unit_req_t        unit_req;
  unit_rsp_t        unit_rsp;
  logic [AddrW-1:0] operand;
  logic             entry_valid;
  logic             match;
  logic             stop_match;
  logic             issue;
  logic             seen_wr;
  logic             region_wr;

  art_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  // During a scan the unit subtracts the stored start from the query; in the
  // finish step it adds the recorded offset onto the other base.
  always_comb begin
    unique case (mode_q)
      MODE_SEEN:  operand = seen_rd_q.base;
      MODE_REV:   operand = reg_rd_q.data;
      default:    operand = reg_rd_q.base;
    endcase
    unit_req.sub = (state_q != ST_FINISH);
    unit_req.a   = (state_q == ST_FINISH) ? other_q : req_q.address;
    unit_req.b   = (state_q == ST_FINISH) ? diff_q : operand;
    unit_req.len = reg_rd_q.length;
  end

  assign entry_valid = valid_q[pend_idx_q];

  always_comb begin
    unique case (mode_q)
      MODE_SEEN:  match = unit_rsp.zero;
      MODE_PURGE: match = entry_valid && unit_rsp.zero;
      default:    match = entry_valid && unit_rsp.in_range;
    endcase
  end

  // A seen-base search and a reverse lookup end at their first match.
  assign stop_match = pend_q && match && ((mode_q == MODE_SEEN) || (mode_q == MODE_REV));
  assign issue      = !stop_q && !stop_match && (idx_q < limit_q);
  assign seen_wr    = (state_q == ST_WRITE) && !found_q && (seen_count_q < CW'(REGIONS));
  assign region_wr  = (state_q == ST_WRITE);

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    req_d         = req_q;
    idx_d         = idx_q;
    limit_d       = limit_q;
    pend_d        = pend_q;
    pend_idx_d    = pend_idx_q;
    stop_d        = stop_q;
    found_d       = found_q;
    first_empty_d = first_empty_q;
    hit_d         = hit_q;
    code_d        = code_q;
    slot_d        = slot_q;
    diff_d        = diff_q;
    other_d       = other_q;
    valid_d       = valid_q;
    next_slot_d   = next_slot_q;
    seen_count_d  = seen_count_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;

    // The output register drains on its own, so a new item can be taken
    // while the previous result still waits.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_item_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          stop_d  = 1'b0;
          found_d = 1'b0;
          first_empty_d = 1'b0;
          hit_d   = 1'b0;
          code_d  = 1'b0;
          slot_d  = '0;
          res_d   = '0;
          unique case (in_item_i.command)
            CMD_INSERT: begin
              mode_d  = MODE_SEEN;
              limit_d = seen_count_q;
              state_d = ST_SCAN;
            end
            CMD_LOOKUP: begin
              mode_d  = MODE_LOOK;
              limit_d = next_slot_q;
              state_d = ST_SCAN;
            end
            CMD_REVERSE: begin
              mode_d  = MODE_REV;
              limit_d = next_slot_q;
              state_d = ST_SCAN;
            end
            default: begin
              res_d.status = STAT_MISS;
              state_d      = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // One read is issued per cycle; its data is examined in the next cycle.
        pend_d = issue;
        if (issue) begin
          idx_d      = idx_q + CW'(1);
          pend_idx_d = idx_q[IW-1:0];
        end
        if (pend_q && match) begin
          unique case (mode_q)
            MODE_SEEN: begin
              found_d       = 1'b1;
              first_empty_d = seen_rd_q.empty;
              stop_d        = 1'b1;
            end
            MODE_PURGE: begin
              valid_d[pend_idx_q] = 1'b0;
            end
            MODE_LOOK: begin
              if (!hit_q) begin
                hit_d         = 1'b1;
                slot_d        = pend_idx_q;
                diff_d        = unit_rsp.sum;
                other_d       = reg_rd_q.data;
                first_empty_d = reg_rd_q.empty;
              end
              if (reg_rd_q.text && !reg_rd_q.stub) begin
                code_d = 1'b1;
              end
            end
            MODE_REV: begin
              hit_d   = 1'b1;
              slot_d  = pend_idx_q;
              diff_d  = unit_rsp.sum;
              other_d = reg_rd_q.base;
              stop_d  = 1'b1;
            end
            default: ;
          endcase
        end
        if (!pend_q && !issue) begin
          unique case (mode_q)
            MODE_SEEN: begin
              // Overlap rule: the first region at a base fixes its empty flag.
              priority if (found_q && req_q.is_empty && !first_empty_q) begin
                res_d.status = STAT_SKIP;
                state_d      = ST_RESP;
              end else if (next_slot_q >= CW'(REGIONS)) begin
                res_d.status = STAT_FULL;
                state_d      = ST_RESP;
              end else if (found_q && first_empty_q && !req_q.is_empty) begin
                mode_d  = MODE_PURGE;
                limit_d = next_slot_q;
                idx_d   = '0;
                stop_d  = 1'b0;
              end else begin
                state_d = ST_WRITE;
              end
            end
            MODE_PURGE: begin
              state_d = ST_WRITE;
            end
            default: begin
              if (hit_q) begin
                state_d = ST_FINISH;
              end else begin
                res_d.status = STAT_MISS;
                state_d      = ST_RESP;
              end
            end
          endcase
        end
      end

      ST_WRITE: begin
        valid_d[next_slot_q[IW-1:0]] = 1'b1;
        next_slot_d = next_slot_q + CW'(1);
        if (seen_wr) begin
          seen_count_d = seen_count_q + CW'(1);
        end
        res_d.status     = STAT_OK;
        res_d.slot_index = 4'(next_slot_q[IW-1:0]);
        state_d          = ST_RESP;
      end

      ST_FINISH: begin
        res_d.status     = STAT_OK;
        res_d.slot_index = 4'(slot_q);
        if (mode_q == MODE_LOOK) begin
          res_d.code_hit     = code_q;
          res_d.empty_hit    = first_empty_q;
          res_d.mapped_value = first_empty_q ? '0 : unit_rsp.sum;
        end else begin
          res_d.mapped_value = unit_rsp.sum;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= MODE_SEEN;
      req_q         <= '0;
      idx_q         <= '0;
      limit_q       <= '0;
      pend_q        <= 1'b0;
      pend_idx_q    <= '0;
      stop_q        <= 1'b0;
      found_q       <= 1'b0;
      first_empty_q <= 1'b0;
      hit_q         <= 1'b0;
      code_q        <= 1'b0;
      slot_q        <= '0;
      diff_q        <= '0;
      other_q       <= '0;
      valid_q       <= '0;
      next_slot_q   <= '0;
      seen_count_q  <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      mode_q        <= mode_d;
      req_q         <= req_d;
      idx_q         <= idx_d;
      limit_q       <= limit_d;
      pend_q        <= pend_d;
      pend_idx_q    <= pend_idx_d;
      stop_q        <= stop_d;
      found_q       <= found_d;
      first_empty_q <= first_empty_d;
      hit_q         <= hit_d;
      code_q        <= code_d;
      slot_q        <= slot_d;
      diff_q        <= diff_d;
      other_q       <= other_d;
      valid_q       <= valid_d;
      next_slot_q   <= next_slot_d;
      seen_count_q  <= seen_count_d;
      res_q         <= res_d;
      out_q         <= out_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Region table: written at the next free slot, read at the scan index.
  always_ff @(posedge clk_i) begin
    if (region_wr) begin
      region_mem[next_slot_q[IW-1:0]] <= '{
        base:   req_q.address,
        length: req_q.region_size,
        data:   req_q.data_base,
        text:   req_q.is_text,
        empty:  req_q.is_empty,
        stub:   req_q.is_stub
      };
    end
    reg_rd_q <= region_mem[idx_q[IW-1:0]];
  end

  // Seen-base table: one entry per distinct base, in order of first insert.
  always_ff @(posedge clk_i) begin
    if (seen_wr) begin
      seen_mem[seen_count_q[IW-1:0]] <= '{base: req_q.address, empty: req_q.is_empty};
    end
    seen_rd_q <= seen_mem[idx_q[IW-1:0]];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Slots are consumed in order and never beyond the table size.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= CW'(REGIONS))
    else $error("next slot beyond table size");

  // Every distinct base consumed a slot when it was first inserted.
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_count_q <= next_slot_q)
    else $error("seen count ahead of slot count");

  // No slot at or above the next free slot is ever valid.
  a_valid_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q >> next_slot_q) == '0)
    else $error("valid slot above next free slot");

  // The slot counter moves by at most one per cycle.
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_slot_q == $past(next_slot_q)) || (next_slot_q == $past(next_slot_q) + CW'(1)))
    else $error("slot counter jumped");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

endmodule
